[sv/isbc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package isbc_pkg;

    localparam int RAW_W    = 16;
    localparam int SCALE_W  = 25;
    localparam int GRAV_W   = 24;
    localparam int PROD_W   = RAW_W + SCALE_W;
    localparam int FRAC_SH  = 16;
    localparam int SCALED_W = PROD_W - FRAC_SH;
    localparam int SUM_W    = 40;
    localparam int OUT_W    = 32;
    localparam int LANES    = 6;
    localparam int DIV_DIG_W  = 8;
    localparam int DIV_DIGITS = SUM_W / DIV_DIG_W;
    localparam int DIV_CNT_W  = $clog2(DIV_DIGITS);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // register index codes
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_SCALE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY     = 2'd2;

    localparam logic [SCALE_W-1:0] ACCEL_SCALE_RST = 25'd20566045;
    localparam logic [SCALE_W-1:0] GYRO_SCALE_RST  = 25'd4685084;
    localparam logic [GRAV_W-1:0]  GRAVITY_RST     = 24'd642689;

    typedef enum logic [1:0] {
        ACT_CLEAR,
        ACT_ACCUM,
        ACT_FINAL,
        ACT_EMIT
    } action_t;

    typedef struct packed {
        logic signed [RAW_W-1:0] accel_x_raw;
        logic signed [RAW_W-1:0] accel_y_raw;
        logic signed [RAW_W-1:0] accel_z_raw;
        logic signed [RAW_W-1:0] gyro_x_raw;
        logic signed [RAW_W-1:0] gyro_y_raw;
        logic signed [RAW_W-1:0] gyro_z_raw;
    } sample_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] accel_x_out;
        logic signed [OUT_W-1:0] accel_y_out;
        logic signed [OUT_W-1:0] accel_z_out;
        logic signed [OUT_W-1:0] gyro_x_out;
        logic signed [OUT_W-1:0] gyro_y_out;
        logic signed [OUT_W-1:0] gyro_z_out;
    } result_t;

    typedef struct packed {
        logic load;
        logic clear;
        logic accum;
        logic div_start;
        logic div_step;
        logic div_done;
        logic out_load;
    } lane_ctl_t;

endpackage

`default_nettype wire

[sv/imu_scale_and_bias_calibrate.sv]
// an accepted sample is registered in the lanes' scaled stage, then its result
// in the output register; six parallel multiply/add lanes take one sample per
// cycle unless the output stalls; the calibration-closing sample starts a
// byte-per-cycle reciprocal divider per lane; new samples wait for the offsets
// reset: asynchronous, active low; clears the sample count, calibrated flag,
// sums, offsets and output valid, and restores the scale and gravity registers
`timescale 1ns / 1ps
`default_nettype none

module imu_scale_and_bias_calibrate
    import isbc_pkg::*;
#(
    parameter int unsigned CAL_SAMPLES = 257
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  sample_valid,
    output logic                       sample_stall,
    input  wire sample_t               sample_data,
    output logic                       result_valid,
    input  wire logic                  result_stall,
    output result_t                    result_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CNT_W = $clog2(CAL_SAMPLES + 1);
    localparam int unsigned DIVISOR = CAL_SAMPLES - 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CAL_SAMPLES);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_DIGITS - 1);

    logic [SCALE_W-1:0] accel_scale_reg;
    logic [SCALE_W-1:0] gyro_scale_reg;
    logic [GRAV_W-1:0]  gravity_reg;

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 calib_reg;
    logic                 calib_next;
    logic                 b_valid_reg;
    action_t              b_act_reg;
    action_t              act_in;
    logic                 result_valid_reg;
    logic                 div_pend_reg;
    logic                 div_busy_reg;
    logic                 div_done_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    logic      accept;
    logic      out_can_load;
    logic      b_moves;
    logic      b_free;
    lane_ctl_t ctl;

    logic signed [RAW_W-1:0] lane_raw [LANES];
    logic [SCALE_W-1:0]      lane_scale [LANES];
    logic [GRAV_W-1:0]       lane_sub [LANES];
    logic signed [OUT_W-1:0] lane_out [LANES];

    // configuration port
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_scale_reg <= ACCEL_SCALE_RST;
            gyro_scale_reg  <= GYRO_SCALE_RST;
            gravity_reg     <= GRAVITY_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ACCEL_SCALE: accel_scale_reg <= cfg_data[SCALE_W-1:0];
                REG_GYRO_SCALE:  gyro_scale_reg  <= cfg_data[SCALE_W-1:0];
                REG_GRAVITY:     gravity_reg     <= cfg_data[GRAV_W-1:0];
                default:         ;
            endcase
        end
    end

    // handshake and pipeline flow
    assign out_can_load = !result_valid_reg || !result_stall;
    assign b_moves      = b_valid_reg && ((b_act_reg != ACT_EMIT) || out_can_load);
    assign b_free       = !b_valid_reg || b_moves;
    assign sample_stall = div_pend_reg || !b_free;
    assign accept       = sample_valid && !sample_stall;

    // decide each request's role in arrival order
    always_comb
    begin
        count_next = count_reg;
        calib_next = calib_reg;
        priority if (calib_reg)
        begin
            act_in = ACT_EMIT;
        end
        else if (count_reg == '0)
        begin
            act_in     = ACT_CLEAR;
            count_next = CNT_W'(1);
        end
        else if (count_reg < CNT_LAST)
        begin
            act_in     = ACT_ACCUM;
            count_next = count_reg + CNT_W'(1);
        end
        else
        begin
            act_in     = ACT_FINAL;
            count_next = count_reg + CNT_W'(1);
            calib_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            calib_reg   <= 1'b0;
            b_valid_reg <= 1'b0;
            b_act_reg   <= ACT_CLEAR;
        end
        else if (accept)
        begin
            count_reg   <= count_next;
            calib_reg   <= calib_next;
            b_valid_reg <= 1'b1;
            b_act_reg   <= act_in;
        end
        else if (b_moves)
        begin
            b_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (ctl.out_load)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    // divider sequencing, shared by all lanes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_pend_reg <= 1'b0;
            div_busy_reg <= 1'b0;
            div_done_reg <= 1'b0;
            div_cnt_reg  <= '0;
        end
        else
        begin
            div_done_reg <= 1'b0;
            if (accept && (act_in == ACT_FINAL))
            begin
                div_pend_reg <= 1'b1;
            end
            else if (div_done_reg)
            begin
                div_pend_reg <= 1'b0;
            end
            if (ctl.div_start)
            begin
                div_busy_reg <= 1'b1;
                div_cnt_reg  <= '0;
            end
            else if (div_busy_reg)
            begin
                div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_LAST)
                begin
                    div_busy_reg <= 1'b0;
                    div_done_reg <= 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        ctl.load      = accept;
        ctl.clear     = b_moves && (b_act_reg == ACT_CLEAR);
        ctl.accum     = b_moves && (b_act_reg == ACT_ACCUM);
        ctl.div_start = b_moves && (b_act_reg == ACT_FINAL);
        ctl.div_step  = div_busy_reg;
        ctl.div_done  = div_done_reg;
        ctl.out_load  = b_valid_reg && (b_act_reg == ACT_EMIT) && out_can_load;
    end

    // lane inputs; gravity comes off the accel z sum only
    always_comb
    begin
        lane_raw[0] = sample_data.accel_x_raw;
        lane_raw[1] = sample_data.accel_y_raw;
        lane_raw[2] = sample_data.accel_z_raw;
        lane_raw[3] = sample_data.gyro_x_raw;
        lane_raw[4] = sample_data.gyro_y_raw;
        lane_raw[5] = sample_data.gyro_z_raw;
        for (int i = 0; i < LANES; i++)
        begin
            lane_scale[i] = (i < 3) ? accel_scale_reg : gyro_scale_reg;
            lane_sub[i]   = (i == 2) ? gravity_reg : '0;
        end
    end

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        isbc_lane #(
            .DIVISOR (DIVISOR)
        ) u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .raw      (lane_raw[g]),
            .scale    (lane_scale[g]),
            .bias_sub (lane_sub[g]),
            .ctl      (ctl),
            .result   (lane_out[g])
        );
    end

    // merge lane results into one result request
    always_comb
    begin
        result_data.accel_x_out = lane_out[0];
        result_data.accel_y_out = lane_out[1];
        result_data.accel_z_out = lane_out[2];
        result_data.gyro_x_out  = lane_out[3];
        result_data.gyro_y_out  = lane_out[4];
        result_data.gyro_z_out  = lane_out[5];
    end

    assign result_valid = result_valid_reg;

endmodule

`default_nettype wire

[sv/isbc_div.sv]
`timescale 1ns / 1ps
`default_nettype none

module isbc_div
    import isbc_pkg::*;
#(
    parameter int unsigned DIVISOR = 256
)
(
    input  wire logic             clk,
    input  wire logic             start,
    input  wire logic             step,
    input  wire logic [SUM_W-1:0] dividend,
    output logic      [SUM_W-1:0] quotient
);

    localparam int PART_W  = 2 * DIV_DIG_W;
    localparam int RECIP_W = PART_W + 2;
    localparam int SH      = PART_W + $clog2(DIVISOR);
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [RECIP_W-1:0]  RECIP = RECIP_W'(RECIP_FULL);
    localparam logic [DIV_DIG_W:0]  DIV_K = (DIV_DIG_W + 1)'(DIVISOR);

    logic [SUM_W-1:0]          quo_reg;
    logic [SUM_W-1:0]          quo_next;
    logic [DIV_DIG_W-1:0]      rem_reg;
    logic [DIV_DIG_W-1:0]      rem_next;
    logic [PART_W-1:0]         part;
    logic [PART_W+RECIP_W-1:0] prod;
    logic [DIV_DIG_W-1:0]      digit;
    logic [PART_W:0]           back;

    // one quotient byte per step; the remainder is below the divisor, so
    // remainder and next dividend byte stay within 16 bits and a reciprocal
    // multiply gives the exact digit; dividend shifts out of the top while
    // quotient bytes shift in at the bottom
    always_comb
    begin
        part     = {rem_reg, quo_reg[SUM_W-1 -: DIV_DIG_W]};
        prod     = {{RECIP_W{1'b0}}, part} * {{PART_W{1'b0}}, RECIP};
        digit    = prod[SH +: DIV_DIG_W];
        back     = {{(DIV_DIG_W + 1){1'b0}}, digit} * {{DIV_DIG_W{1'b0}}, DIV_K};
        rem_next = DIV_DIG_W'({1'b0, part} - back);
        quo_next = {quo_reg[SUM_W-DIV_DIG_W-1:0], digit};
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (step)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient = quo_reg;

endmodule

`default_nettype wire

[sv/isbc_lane.sv]
`timescale 1ns / 1ps
`default_nettype none

module isbc_lane
    import isbc_pkg::*;
#(
    parameter int unsigned DIVISOR = 256
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic signed [RAW_W-1:0] raw,
    input  wire logic [SCALE_W-1:0]      scale,
    input  wire logic [GRAV_W-1:0]       bias_sub,
    input  wire lane_ctl_t               ctl,
    output logic signed [OUT_W-1:0]      result
);

    logic signed [PROD_W-1:0]   product;
    logic signed [SCALED_W-1:0] scaled_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic signed [SUM_W-1:0]    sum_next;
    logic [SUM_W-1:0]           sum_mag;
    logic                       neg_reg;
    logic [SUM_W-1:0]           quotient;
    logic signed [OUT_W-1:0]    offset_reg;
    logic signed [OUT_W-1:0]    offset_next;
    logic signed [OUT_W:0]      corrected;
    logic signed [OUT_W-1:0]    sat_val;
    logic signed [OUT_W-1:0]    result_reg;

    // floor(count * scale / 2^16) is an arithmetic shift of the product
    assign product = $signed({{SCALE_W{raw[RAW_W-1]}}, raw})
                   * $signed({{RAW_W{1'b0}}, scale});

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            scaled_reg <= product[PROD_W-1:FRAC_SH];
        end
    end

    assign sum_next = sum_reg
                    + $signed({{(SUM_W - SCALED_W){scaled_reg[SCALED_W-1]}}, scaled_reg})
                    - $signed({{(SUM_W - GRAV_W){1'b0}}, bias_sub});

    assign sum_mag = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (ctl.clear)
        begin
            sum_reg <= '0;
        end
        else if (ctl.accum)
        begin
            sum_reg <= sum_next;
        end
    end

    isbc_div #(
        .DIVISOR (DIVISOR)
    ) u_div (
        .clk      (clk),
        .start    (ctl.div_start),
        .step     (ctl.div_step),
        .dividend (sum_mag),
        .quotient (quotient)
    );

    always_ff @(posedge clk)
    begin
        if (ctl.div_start)
        begin
            neg_reg <= sum_reg[SUM_W-1];
        end
    end

    // offset is the negated average, truncated toward zero
    assign offset_next = neg_reg ? $signed(quotient[OUT_W-1:0])
                                 : -$signed(quotient[OUT_W-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
        end
        else if (ctl.div_done)
        begin
            offset_reg <= offset_next;
        end
    end

    assign corrected = $signed({{(OUT_W + 1 - SCALED_W){scaled_reg[SCALED_W-1]}}, scaled_reg})
                     + $signed({offset_reg[OUT_W-1], offset_reg});

    always_comb
    begin
        if (corrected[OUT_W] != corrected[OUT_W-1])
        begin
            sat_val = corrected[OUT_W] ? $signed({1'b1, {(OUT_W - 1){1'b0}}})
                                       : $signed({1'b0, {(OUT_W - 1){1'b1}}});
        end
        else
        begin
            sat_val = corrected[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            result_reg <= sat_val;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

[sv/isbc_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module isbc_checker
    import isbc_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    sample_valid,
    input wire logic    sample_stall,
    input wire logic    result_valid,
    input wire logic    result_stall,
    input wire result_t result_data
);

    // a stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_data))
        else $error("stalled result changed");

    // a fresh result follows an earlier accepted request
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(sample_valid && !sample_stall, 2))
        else $error("result without a matching request");

    // nothing is presented right out of reset
    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !result_valid)
        else $error("result valid at reset release");

endmodule

bind imu_scale_and_bias_calibrate isbc_checker u_isbc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
);

`default_nettype wire
